[rtl/jllc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jllc_pkg
// Shared types, codes and reset values of the jog/latch local command unit.
// ----------------------------------------------------------------------------
package jllc_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned SysW  = 2;
  localparam int unsigned CalW  = 2;
  localparam int unsigned CntW  = 8;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Event codes
  localparam logic [ModeW-1:0] EV_LOCK_TICK    = 3'd0;
  localparam logic [ModeW-1:0] EV_OPEN_PRESS   = 3'd1;
  localparam logic [ModeW-1:0] EV_CLOSE_PRESS  = 3'd2;
  localparam logic [ModeW-1:0] EV_CAL_TICK     = 3'd3;
  localparam logic [ModeW-1:0] EV_CONTROL_TICK = 3'd4;

  // Motor commands
  localparam logic [CmdW-1:0] CMD_STOP  = 2'd0;
  localparam logic [CmdW-1:0] CMD_OPEN  = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLOSE = 2'd2;

  // System modes
  localparam logic [SysW-1:0] SYS_LOCAL  = 2'd0;
  localparam logic [SysW-1:0] SYS_CAL_HI = 2'd1;
  localparam logic [SysW-1:0] SYS_CAL_LO = 2'd2;

  // Calibration requests
  localparam logic [CalW-1:0] CAL_NONE = 2'd0;
  localparam logic [CalW-1:0] CAL_HI   = 2'd1;
  localparam logic [CalW-1:0] CAL_LO   = 2'd2;

  // Register indexes (word address bit 2)
  localparam logic REG_LOCK_DELAY = 1'b0;
  localparam logic REG_CAL_HOLD   = 1'b1;

  localparam logic [CntW-1:0] LOCK_DELAY_RESET = 8'd40;
  localparam logic [CntW-1:0] CAL_HOLD_RESET   = 8'd15;

  typedef struct packed {
    logic [CntW-1:0] lock_delay;
    logic [CntW-1:0] cal_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             open_pressed;
    logic             close_pressed;
    logic             stop_pressed;
    logic             local_selected;
    logic [SysW-1:0]  system_mode;
    logic             direct_valid;
    logic [CmdW-1:0]  direct_command;
  } item_t;

endpackage

[rtl/jllc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jllc_if
// Request channels of the jog/latch local command unit: event in, result out.
// ----------------------------------------------------------------------------
interface jllc_in_if import jllc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic             open_pressed;
  logic             close_pressed;
  logic             stop_pressed;
  logic             local_selected;
  logic [SysW-1:0]  system_mode;
  logic             direct_valid;
  logic [CmdW-1:0]  direct_command;

  modport source (output valid, mode, open_pressed, close_pressed, stop_pressed,
                  local_selected, system_mode, direct_valid, direct_command,
                  input ready);
  modport sink (input valid, mode, open_pressed, close_pressed, stop_pressed,
                local_selected, system_mode, direct_valid, direct_command,
                output ready);
endinterface

interface jllc_out_if import jllc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic            latched;
  logic [CalW-1:0] cal_request;

  modport source (output valid, command, latched, cal_request, input ready);
  modport sink (input valid, command, latched, cal_request, output ready);
endinterface

[rtl/jllc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jllc_regs
// APB register file: lock delay and calibration hold reload.
// ----------------------------------------------------------------------------
module jllc_regs import jllc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_delay     <= LOCK_DELAY_RESET;
      cfg_r.cal_hold_ticks <= CAL_HOLD_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_LOCK_DELAY: cfg_r.lock_delay     <= cfg_pwdata[CntW-1:0];
        REG_CAL_HOLD:   cfg_r.cal_hold_ticks <= cfg_pwdata[CntW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_LOCK_DELAY: cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.lock_delay};
      REG_CAL_HOLD:   cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.cal_hold_ticks};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/jllc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jllc_core
// Input register, panel state update and result register.
// ----------------------------------------------------------------------------
module jllc_core import jllc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  jllc_in_if.sink    in_ch,
  jllc_out_if.source out_ch
);

  // Input stage
  logic  in_v_r;
  item_t in_r;
  item_t in_item;
  logic  advance;
  logic  out_free;

  // Panel state
  logic [CmdW-1:0] cmd_r, cmd_nxt;
  logic [CntW-1:0] lock_cnt_r, lock_cnt_nxt;
  logic            latched_r, latched_nxt;
  logic            active_r, active_nxt;
  logic [CntW-1:0] cal_cnt_r, cal_cnt_nxt;
  logic [CalW-1:0] req_nxt;
  logic            allowed;

  // Result stage
  logic            out_v_r;
  logic [CmdW-1:0] out_cmd_r;
  logic            out_lat_r;
  logic [CalW-1:0] out_req_r;

  assign in_item = '{mode: in_ch.mode, open_pressed: in_ch.open_pressed,
                     close_pressed: in_ch.close_pressed,
                     stop_pressed: in_ch.stop_pressed,
                     local_selected: in_ch.local_selected,
                     system_mode: in_ch.system_mode,
                     direct_valid: in_ch.direct_valid,
                     direct_command: in_ch.direct_command};

  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_item;
    end
  end

  assign allowed = in_r.local_selected || (in_r.system_mode == SYS_CAL_HI) ||
                   (in_r.system_mode == SYS_CAL_LO);

  always_comb begin
    cmd_nxt      = cmd_r;
    lock_cnt_nxt = lock_cnt_r;
    latched_nxt  = latched_r;
    active_nxt   = active_r;
    cal_cnt_nxt  = cal_cnt_r;
    req_nxt      = CAL_NONE;
    unique case (in_r.mode)
      EV_LOCK_TICK: begin
        if (active_r) begin
          if (in_r.open_pressed || in_r.close_pressed) begin
            if (lock_cnt_r < cfg.lock_delay) begin
              lock_cnt_nxt = lock_cnt_r + 1'b1;
            end else begin
              latched_nxt = 1'b1;
            end
          end else begin
            active_nxt = 1'b0;
            if (!latched_r) begin
              cmd_nxt = CMD_STOP;
            end
          end
        end
      end
      EV_OPEN_PRESS, EV_CLOSE_PRESS: begin
        if (allowed && ((in_r.mode == EV_OPEN_PRESS) ? in_r.open_pressed
                                                      : in_r.close_pressed)) begin
          cmd_nxt      = (in_r.mode == EV_OPEN_PRESS) ? CMD_OPEN : CMD_CLOSE;
          lock_cnt_nxt = '0;
          latched_nxt  = 1'b0;
          active_nxt   = 1'b1;
        end
      end
      EV_CAL_TICK: begin
        if (in_r.stop_pressed && (in_r.system_mode == SYS_LOCAL)) begin
          if (in_r.open_pressed || in_r.close_pressed) begin
            if (cal_cnt_r != '0) begin
              cal_cnt_nxt = cal_cnt_r - 1'b1;
            end else begin
              cal_cnt_nxt = cfg.cal_hold_ticks;
              req_nxt     = in_r.open_pressed ? CAL_HI : CAL_LO;
            end
          end else begin
            cal_cnt_nxt = cfg.cal_hold_ticks;
          end
        end
      end
      EV_CONTROL_TICK: begin
        if (in_r.direct_valid && (in_r.direct_command <= CMD_CLOSE)) begin
          cmd_nxt = in_r.direct_command;
        end
        if (in_r.stop_pressed) begin
          cmd_nxt = CMD_STOP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= CMD_STOP;
      lock_cnt_r <= '0;
      latched_r  <= 1'b0;
      active_r   <= 1'b0;
      cal_cnt_r  <= CAL_HOLD_RESET;
    end else if (advance) begin
      cmd_r      <= cmd_nxt;
      lock_cnt_r <= lock_cnt_nxt;
      latched_r  <= latched_nxt;
      active_r   <= active_nxt;
      cal_cnt_r  <= cal_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmd_r <= cmd_nxt;
      out_lat_r <= latched_nxt;
      out_req_r <= req_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.command     = out_cmd_r;
  assign out_ch.latched     = out_lat_r;
  assign out_ch.cal_request = out_req_r;

endmodule

[rtl/jog_latch_local_command_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jog_latch_local_command_unit
// Local panel command logic of a valve actuator: jog, latch, stop, calibrate.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event request per accepted valid/ready beat: the event
//   code plus the debounced open, close, stop and local-selector levels, the
//   system mode and an optional direct command.
//   out_ch returns exactly one result request per event: the motor command
//   after the event, the latched flag and any calibration request.
//   The APB port (cfg_*) holds lock_delay at 0x0 and cal_hold_ticks at 0x4;
//   write them only while no event is in flight.
// Timing:
//   An accepted event sits in the input register; the state update and the
//   result register load follow once the result register is free, and the
//   result is then offered on out_ch until it is taken.
//   One event per cycle is sustained while out_ch.ready stays high; the single
//   state update between input and result register sets that figure.
// Reset (rst_n low, synchronous): motor stopped, lock timer idle, calibration
//   hold counter at 15, registers at their reset values, both stages empty.
// Stall: when out_ch.ready is low the result register holds; the input
//   register still takes one more event, then in_ch.ready drops until the
//   result drains.
// ----------------------------------------------------------------------------
module jog_latch_local_command_unit import jllc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  jllc_in_if.sink          in_ch,
  jllc_out_if.source       out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t cfg;

  // Register file: take writes at the APB access phase
  jllc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Event pipeline: input register, state update, result register
  jllc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Reset must empty the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // Commands never take the unused code
  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.command == CMD_STOP || out_ch.command == CMD_OPEN ||
                      out_ch.command == CMD_CLOSE))
    else $error("illegal motor command");

  // A calibration request never comes with the unused code
  a_req_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cal_request == CAL_NONE ||
                      out_ch.cal_request == CAL_HI ||
                      out_ch.cal_request == CAL_LO))
    else $error("illegal calibration request");

  // A result cannot appear without an event having been accepted before
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
    else $error("result without an accepted event");

endmodule

[verif/jog_latch_local_command_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jog_latch_local_command_unit_test
// Self-checking bench for the jog/latch local command unit.
// A scoreboard class models the panel state (motor command, lock timer and
// calibration hold counter) and predicts one result per accepted event. The
// bench runs a short directed list, then random press/hold/release, calibration
// hold, control-tick and noise sequences across several register settings.
// Both channel sides idle at random, and every result is checked in order.
// ----------------------------------------------------------------------------
module jog_latch_local_command_unit_test;
  import jllc_pkg::*;

  // One result request as seen on the output channel.
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic            latched;
    logic [CalW-1:0] cal_request;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: panel state model plus the queue of expected results.
  // --------------------------------------------------------------------------
  class command_scoreboard;
    logic [CntW-1:0] lock_delay;
    logic [CntW-1:0] cal_hold_ticks;
    logic [CmdW-1:0] motor_cmd;
    logic [CntW-1:0] lock_count;
    logic            lock_latched;
    logic            lock_active;
    logic [CntW-1:0] cal_count;
    result_t         expected_q[$];
    int unsigned     mismatches;
    int unsigned     checked;

    function new();
      lock_delay     = LOCK_DELAY_RESET;
      cal_hold_ticks = CAL_HOLD_RESET;
      motor_cmd      = CMD_STOP;
      lock_count     = '0;
      lock_latched   = 1'b0;
      lock_active    = 1'b0;
      cal_count      = CAL_HOLD_RESET;
      mismatches     = 0;
      checked        = 0;
    endfunction

    // Count one calibration hold tick; report when the hold is complete.
    function bit hold_done();
      if (cal_count != 0) begin
        cal_count = cal_count - 1'b1;
        return 1'b0;
      end
      cal_count = cal_hold_ticks;
      return 1'b1;
    endfunction

    function void start_motion(logic [CmdW-1:0] cmd);
      motor_cmd    = cmd;
      lock_count   = '0;
      lock_latched = 1'b0;
      lock_active  = 1'b1;
    endfunction

    // Apply one accepted event to the model and queue its result.
    function void note_request(item_t it);
      result_t r;
      bit      allowed;
      allowed = it.local_selected || it.system_mode == SYS_CAL_HI ||
                it.system_mode == SYS_CAL_LO;
      r.cal_request = CAL_NONE;
      case (it.mode)
        EV_LOCK_TICK: begin
          if (lock_active) begin
            if (it.open_pressed || it.close_pressed) begin
              if (lock_count < lock_delay) lock_count = lock_count + 1'b1;
              else lock_latched = 1'b1;
            end else begin
              lock_active = 1'b0;
              if (!lock_latched) motor_cmd = CMD_STOP;
            end
          end
        end
        EV_OPEN_PRESS: begin
          if (it.open_pressed && allowed) start_motion(CMD_OPEN);
        end
        EV_CLOSE_PRESS: begin
          if (it.close_pressed && allowed) start_motion(CMD_CLOSE);
        end
        EV_CAL_TICK: begin
          if (it.stop_pressed && it.system_mode == SYS_LOCAL) begin
            if (it.open_pressed) begin
              if (hold_done()) r.cal_request = CAL_HI;
            end else if (it.close_pressed) begin
              if (hold_done()) r.cal_request = CAL_LO;
            end else begin
              cal_count = cal_hold_ticks;
            end
          end
        end
        EV_CONTROL_TICK: begin
          if (it.direct_valid && it.direct_command <= CMD_CLOSE)
            motor_cmd = it.direct_command;
          if (it.stop_pressed) motor_cmd = CMD_STOP;
        end
        default: ;
      endcase
      r.command = motor_cmd;
      r.latched = lock_latched;
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cmd=%0d lat=%0d cal=%0d",
                 $time, got.command, got.latched, got.cal_request);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.command !== exp_r.command) begin
        $display("%0t: command mismatch, expected %0d, actual %0d",
                 $time, exp_r.command, got.command);
        mismatches++;
      end
      if (got.latched !== exp_r.latched) begin
        $display("%0t: latched mismatch, expected %0d, actual %0d",
                 $time, exp_r.latched, got.latched);
        mismatches++;
      end
      if (got.cal_request !== exp_r.cal_request) begin
        $display("%0t: cal_request mismatch, expected %0d, actual %0d",
                 $time, exp_r.cal_request, got.cal_request);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic             clk;
  logic             rst_n;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;

  jllc_in_if  in_ch();
  jllc_out_if out_ch();

  jog_latch_local_command_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  command_scoreboard sb;

  // Idle rates in percent; the stimulus walks them through the three stages.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_count;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs the handshake.
  initial begin
    #5ms;
    $display("Timeout after %0t", $time);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, then draw the next ready.
  // Values read here are the ones sampled at this edge.
  // --------------------------------------------------------------------------
  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.command     = out_ch.command;
        got.latched     = out_ch.latched;
        got.cal_request = out_ch.cal_request;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Pick the idle stage from how far the run has come: sender-light first,
  // receiver-light second, then full throughput.
  function void update_idle_rates();
    if (sent_count < 520) begin
      send_idle_pct = 30;
      recv_idle_pct = 60;
    end else if (sent_count < 1040) begin
      send_idle_pct = 60;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Present one event request and hold it until the block accepts it.
  task automatic send_request(item_t it);
    int unsigned gap;
    gap = 0;
    update_idle_rates();
    while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= it.mode;
    in_ch.open_pressed   <= it.open_pressed;
    in_ch.close_pressed  <= it.close_pressed;
    in_ch.stop_pressed   <= it.stop_pressed;
    in_ch.local_selected <= it.local_selected;
    in_ch.system_mode    <= it.system_mode;
    in_ch.direct_valid   <= it.direct_valid;
    in_ch.direct_command <= it.direct_command;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(it);
    sent_count++;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Two-phase register write; the register updates at the access edge.
  task automatic write_register(logic index, logic [CntW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= DataW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (index == REG_LOCK_DELAY) sb.lock_delay = value;
    else sb.cal_hold_ticks = value;
  endtask

  task automatic apply_settings(logic [CntW-1:0] lock_delay, logic [CntW-1:0] hold);
    wait_drained();
    write_register(REG_LOCK_DELAY, lock_delay);
    write_register(REG_CAL_HOLD, hold);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic item_t make_request(logic [ModeW-1:0] mode, bit op, bit cl, bit st,
                                         bit loc, logic [SysW-1:0] sys, bit dv,
                                         logic [CmdW-1:0] dc);
    item_t it;
    it.mode           = mode;
    it.open_pressed   = op;
    it.close_pressed  = cl;
    it.stop_pressed   = st;
    it.local_selected = loc;
    it.system_mode    = sys;
    it.direct_valid   = dv;
    it.direct_command = dc;
    return it;
  endfunction

  // Any field value at all, unused event codes and direct command three included.
  function automatic item_t any_request();
    return make_request(ModeW'($urandom_range(7)), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1), $urandom_range(1),
                        SysW'($urandom_range(3)), $urandom_range(1),
                        CmdW'($urandom_range(3)));
  endfunction

  // Hold length around a threshold: short thresholds are walked past fully,
  // long ones only now and then so the run stays short.
  function automatic int unsigned hold_length(logic [CntW-1:0] limit);
    if (limit <= 16) return $urandom_range(limit + 2);
    if ($urandom_range(3) == 0) return limit + 1 + $urandom_range(1);
    return $urandom_range(12);
  endfunction

  // Press open or close, hold through lock ticks, then mostly release.
  task automatic motion_sequence();
    item_t       it;
    int unsigned n;
    bit          open_dir;
    open_dir = $urandom_range(1);
    it = any_request();
    it.mode = open_dir ? EV_OPEN_PRESS : EV_CLOSE_PRESS;
    if (open_dir) it.open_pressed = 1'b1;
    else it.close_pressed = 1'b1;
    // Mostly grant permission; leave it random now and then.
    if ($urandom_range(7) != 0) begin
      if ($urandom_range(1)) it.local_selected = 1'b1;
      else it.system_mode = $urandom_range(1) ? SYS_CAL_HI : SYS_CAL_LO;
    end
    send_request(it);
    n = hold_length(sb.lock_delay);
    repeat (n) begin
      it = any_request();
      it.mode = EV_LOCK_TICK;
      if (!it.open_pressed && !it.close_pressed) begin
        if (open_dir) it.open_pressed = 1'b1;
        else it.close_pressed = 1'b1;
      end
      send_request(it);
    end
    if ($urandom_range(3) != 0) begin
      it = any_request();
      it.mode          = EV_LOCK_TICK;
      it.open_pressed  = 1'b0;
      it.close_pressed = 1'b0;
      send_request(it);
    end
  endtask

  // Hold stop with open or close in local mode on calibration ticks.
  task automatic calibration_sequence();
    item_t       it;
    int unsigned n;
    bit          open_btn;
    open_btn = $urandom_range(1);
    n = hold_length(sb.cal_hold_ticks);
    repeat (n) begin
      it = any_request();
      it.mode         = EV_CAL_TICK;
      it.stop_pressed = 1'b1;
      if ($urandom_range(11) != 0) it.system_mode = SYS_LOCAL;
      if (open_btn) begin
        it.open_pressed = 1'b1;
      end else begin
        it.open_pressed  = 1'b0;
        it.close_pressed = 1'b1;
      end
      // Occasionally drop both buttons to reload the counter.
      if ($urandom_range(15) == 0) begin
        it.open_pressed  = 1'b0;
        it.close_pressed = 1'b0;
      end
      send_request(it);
    end
  endtask

  task automatic control_tick();
    item_t it;
    it = any_request();
    it.mode         = EV_CONTROL_TICK;
    it.stop_pressed = ($urandom_range(3) == 0);
    send_request(it);
  endtask

  task automatic random_phase(logic [CntW-1:0] lock_delay, logic [CntW-1:0] hold,
                              int unsigned budget);
    int unsigned start_count;
    int unsigned pick;
    bit          paused;
    apply_settings(lock_delay, hold);
    start_count = sent_count;
    paused = 1'b0;
    while (sent_count - start_count < budget) begin
      // Once per phase, starve the block until it has drained completely.
      if (!paused && sent_count - start_count >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 40) motion_sequence();
      else if (pick < 65) calibration_sequence();
      else if (pick < 80) control_tick();
      else send_request(any_request());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned drain_cycles;
    sb            = new();
    sent_count    = 0;
    settings_used = 1;
    send_idle_pct = 30;
    recv_idle_pct = 60;

    // Drive every input to a known value, then hold reset.
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= EV_LOCK_TICK;
    in_ch.open_pressed   <= 1'b0;
    in_ch.close_pressed  <= 1'b0;
    in_ch.stop_pressed   <= 1'b0;
    in_ch.local_selected <= 1'b0;
    in_ch.system_mode    <= SYS_LOCAL;
    in_ch.direct_valid   <= 1'b0;
    in_ch.direct_command <= CMD_STOP;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed list at the reset register values.
    // Unused event codes report the state and change nothing.
    send_request(make_request(3'd5, 1, 1, 1, 1, 2'd3, 1, 2'd3));
    send_request(make_request(3'd7, 1, 1, 1, 1, 2'd3, 1, 2'd3));
    // Lock tick while idle does nothing.
    send_request(make_request(EV_LOCK_TICK, 0, 0, 0, 0, SYS_LOCAL, 0, CMD_STOP));
    // Presses without permission or without the button level are ignored.
    send_request(make_request(EV_OPEN_PRESS, 1, 0, 0, 0, 2'd3, 0, CMD_STOP));
    send_request(make_request(EV_OPEN_PRESS, 0, 1, 0, 1, SYS_LOCAL, 0, CMD_STOP));
    // Open press in local, one held tick, then release: a jog.
    send_request(make_request(EV_OPEN_PRESS, 1, 0, 0, 1, SYS_LOCAL, 0, CMD_STOP));
    send_request(make_request(EV_LOCK_TICK, 1, 0, 0, 1, SYS_LOCAL, 0, CMD_STOP));
    send_request(make_request(EV_LOCK_TICK, 0, 0, 0, 1, SYS_LOCAL, 0, CMD_STOP));
    // Close press allowed by calibration modes, held once.
    send_request(make_request(EV_CLOSE_PRESS, 0, 1, 0, 0, SYS_CAL_HI, 0, CMD_STOP));
    send_request(make_request(EV_LOCK_TICK, 0, 1, 0, 0, SYS_CAL_HI, 0, CMD_STOP));
    send_request(make_request(EV_CLOSE_PRESS, 0, 1, 0, 0, SYS_CAL_LO, 0, CMD_STOP));
    // Direct command three is ignored; then direct open; then stop wins.
    send_request(make_request(EV_CONTROL_TICK, 0, 0, 0, 0, SYS_LOCAL, 1, 2'd3));
    send_request(make_request(EV_CONTROL_TICK, 0, 0, 0, 0, SYS_LOCAL, 1, CMD_OPEN));
    send_request(make_request(EV_CONTROL_TICK, 0, 0, 1, 0, SYS_LOCAL, 1, CMD_CLOSE));
    send_request(make_request(EV_CONTROL_TICK, 0, 0, 0, 0, SYS_LOCAL, 1, CMD_CLOSE));
    send_request(make_request(EV_CONTROL_TICK, 0, 0, 0, 0, SYS_LOCAL, 1, CMD_STOP));
    // Calibration ticks: both buttons (open wins), stop alone reloads,
    // outside local mode the counter holds.
    send_request(make_request(EV_CAL_TICK, 1, 1, 1, 1, SYS_LOCAL, 0, CMD_STOP));
    send_request(make_request(EV_CAL_TICK, 0, 1, 1, 1, SYS_LOCAL, 0, CMD_STOP));
    send_request(make_request(EV_CAL_TICK, 0, 0, 1, 1, SYS_LOCAL, 0, CMD_STOP));
    send_request(make_request(EV_CAL_TICK, 1, 0, 1, 1, 2'd3, 0, CMD_STOP));
    send_request(make_request(EV_CAL_TICK, 1, 0, 0, 1, SYS_LOCAL, 0, CMD_STOP));

    // Random phases across register settings, extremes included.
    random_phase(8'd0, 8'd0, 300);
    random_phase(8'd3, 8'd2, 300);
    random_phase(8'd255, 8'd255, 300);
    random_phase(8'd9, 8'd6, 300);
    random_phase(8'd1, 8'd1, 300);

    // Let the last results drain, with a bound.
    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (sb.outstanding() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d results never arrived, expected %0d, actual 0",
               $time, sb.outstanding(), sb.outstanding());
      sb.mismatches += sb.outstanding();
    end

    $display("Run covered %0d event requests and %0d checked results", sent_count,
             sb.checked);
    $display("over %0d register settings with jog, latch, stop and calibration holds",
             settings_used);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/jllc_pkg.sv
rtl/jllc_if.sv
rtl/jllc_regs.sv
rtl/jllc_core.sv
rtl/jog_latch_local_command_unit.sv
verif/jog_latch_local_command_unit_test.sv
